// ===== hw/rtl/nrf_pkg.sv =====
package nrf_pkg;

  localparam int COORD_W       = 12;
  localparam int MAX_RECTS_DEF = 32;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

endpackage

// ===== hw/rtl/nrf_contain.sv =====
// Containment test: high when inner lies fully inside outer.
module nrf_contain (
  input  nrf_pkg::rect_t inner,
  input  nrf_pkg::rect_t outer,
  output logic           contained
);
  import nrf_pkg::*;

  logic [COORD_W:0] in_right;
  logic [COORD_W:0] in_bottom;
  logic [COORD_W:0] out_right;
  logic [COORD_W:0] out_bottom;

  // Right and bottom edges carry one extra bit so they never wrap.
  assign in_right   = {1'b0, inner.x} + {1'b0, inner.w};
  assign in_bottom  = {1'b0, inner.y} + {1'b0, inner.h};
  assign out_right  = {1'b0, outer.x} + {1'b0, outer.w};
  assign out_bottom = {1'b0, outer.y} + {1'b0, outer.h};

  assign contained = (outer.x <= inner.x) && (outer.y <= inner.y) &&
                     (in_right <= out_right) && (in_bottom <= out_bottom);

endmodule

// ===== hw/rtl/nested_rectangle_filter.sv =====
// Flow: a set of n stored rectangles is taken at one word per cycle while collecting, then
//   filtered with one containment compare per cycle through a single shared compare unit.
// Output: entries up to the last kept one are scanned and each kept word is sent in turn.
// Input: no new rectangle is taken until the last output word of a set is loaded.
// Reset: synchronous, active high; clears the sequencer, the rectangle count and output valid.
//   The rectangle store is not cleared; entries of a set are written before their read data is used.
module nested_rectangle_filter #(
  parameter int MAX_RECTS = nrf_pkg::MAX_RECTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rect_valid,
  output logic                         rect_ready,
  input  logic [nrf_pkg::COORD_W-1:0]  rect_x,
  input  logic [nrf_pkg::COORD_W-1:0]  rect_y,
  input  logic [nrf_pkg::COORD_W-1:0]  rect_width,
  input  logic [nrf_pkg::COORD_W-1:0]  rect_height,
  input  logic                         set_end,
  output logic                         kept_valid,
  input  logic                         kept_ready,
  output logic [nrf_pkg::COORD_W-1:0]  kept_x,
  output logic [nrf_pkg::COORD_W-1:0]  kept_y,
  output logic [nrf_pkg::COORD_W-1:0]  kept_width,
  output logic [nrf_pkg::COORD_W-1:0]  kept_height,
  output logic                         run_last,
  output logic                         none_kept,
  output logic                         overflow
);
  import nrf_pkg::*;

  localparam int IW = $clog2(MAX_RECTS);
  localparam int CW = $clog2(MAX_RECTS + 1);

  typedef enum logic [2:0] {
    S_COLLECT,
    S_FETCH,
    S_CUR,
    S_SCAN,
    S_EMIT,
    S_LOAD,
    S_NONE
  } state_t;

  state_t               state;
  rect_t                store [MAX_RECTS];
  rect_t                rd_data;
  rect_t                wr_data;
  rect_t                cur;
  logic [IW-1:0]        rd_addr;
  logic                 wr_en;
  logic [CW-1:0]        rect_count;
  logic                 overflow_seen;
  logic [IW-1:0]        i;
  logic [CW-1:0]        j;
  logic [IW-1:0]        pj;
  logic                 covered;
  logic                 covered_now;
  logic                 encl;
  logic [MAX_RECTS-1:0] keep;
  logic [IW-1:0]        last_kept;
  logic                 any_kept;
  logic [IW-1:0]        e;
  logic [CW-1:0]        i_inc;
  logic                 in_acc;
  logic                 out_free;

  assign rect_ready = (state == S_COLLECT);
  assign in_acc     = rect_valid && rect_ready;
  assign wr_en      = in_acc && (rect_count < CW'(MAX_RECTS));
  assign out_free   = !kept_valid || kept_ready;
  assign i_inc      = CW'(i) + CW'(1);

  // Zero extent counts as one pixel.
  always_comb begin
    wr_data.x = rect_x;
    wr_data.y = rect_y;
    wr_data.w = (rect_width == '0) ? COORD_W'(1) : rect_width;
    wr_data.h = (rect_height == '0) ? COORD_W'(1) : rect_height;
  end

  // Shared compare unit: the candidate being tested is the inner rectangle,
  // the word streaming out of the store is the outer one.
  nrf_contain u_contain (
    .inner     (cur),
    .outer     (rd_data),
    .contained (encl)
  );

  assign covered_now = covered || ((pj != i) && encl);

  // Read address of the single store port.
  always_comb begin
    case (state)
      S_CUR:   rd_addr = '0;
      S_SCAN:  rd_addr = (j != rect_count) ? j[IW-1:0] : i_inc[IW-1:0];
      S_EMIT:  rd_addr = e;
      default: rd_addr = '0;
    endcase
  end

  // Rectangle store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[rect_count[IW-1:0]] <= wr_data;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_COLLECT;
      rect_count    <= '0;
      overflow_seen <= 1'b0;
      any_kept      <= 1'b0;
      kept_valid    <= 1'b0;
    end else begin
      // Drop the output word once taken; the load states handle their own valid.
      if (kept_valid && kept_ready && (state != S_NONE) && (state != S_LOAD)) begin
        kept_valid <= 1'b0;
      end
      case (state)
        S_COLLECT: begin
          if (in_acc) begin
            if (wr_en) begin
              rect_count <= rect_count + CW'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            // Close the set and start the pairwise sweep.
            if (set_end) begin
              i        <= '0;
              any_kept <= 1'b0;
              state    <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_CUR;
        end
        S_CUR: begin
          // Latch the candidate and start streaming the set from entry zero.
          cur     <= rd_data;
          covered <= 1'b0;
          pj      <= '0;
          j       <= CW'(1);
          state   <= S_SCAN;
        end
        S_SCAN: begin
          if (j != rect_count) begin
            covered <= covered_now;
            pj      <= j[IW-1:0];
            j       <= j + CW'(1);
          end else begin
            // Last compare of this candidate: record its verdict.
            keep[i] <= !covered_now;
            if (!covered_now) begin
              last_kept <= i;
              any_kept  <= 1'b1;
            end
            if (i_inc == rect_count) begin
              e     <= '0;
              state <= (any_kept || !covered_now) ? S_EMIT : S_NONE;
            end else begin
              i     <= i_inc[IW-1:0];
              state <= S_CUR;
            end
          end
        end
        S_EMIT: begin
          // Skip dropped entries; for a kept one wait for a free output slot.
          if (keep[e]) begin
            if (out_free) begin
              state <= S_LOAD;
            end
          end else begin
            e <= e + IW'(1);
          end
        end
        S_LOAD: begin
          kept_valid  <= 1'b1;
          kept_x      <= rd_data.x;
          kept_y      <= rd_data.y;
          kept_width  <= rd_data.w;
          kept_height <= rd_data.h;
          none_kept   <= 1'b0;
          overflow    <= overflow_seen;
          run_last    <= (e == last_kept);
          if (e == last_kept) begin
            rect_count    <= '0;
            overflow_seen <= 1'b0;
            state         <= S_COLLECT;
          end else begin
            e     <= e + IW'(1);
            state <= S_EMIT;
          end
        end
        S_NONE: begin
          if (out_free) begin
            kept_valid    <= 1'b1;
            kept_x        <= '0;
            kept_y        <= '0;
            kept_width    <= '0;
            kept_height   <= '0;
            none_kept     <= 1'b1;
            run_last      <= 1'b1;
            overflow      <= overflow_seen;
            rect_count    <= '0;
            overflow_seen <= 1'b0;
            state         <= S_COLLECT;
          end
        end
        default: begin
          state <= S_COLLECT;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rect_count <= CW'(MAX_RECTS))
    else $error("rectangle count beyond store depth");

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    (kept_valid && none_kept) |-> run_last)
    else $error("empty-set word not marked last");

  a_close_blocks: assert property (@(posedge clk) disable iff (rst)
    (rect_valid && rect_ready && set_end) |=> !rect_ready)
    else $error("input still open after set closed");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> (e <= last_kept))
    else $error("output scan ran past last kept entry");
`endif

endmodule

// ===== tb/nested_rectangle_filter_tb.sv =====
module nested_rectangle_filter_tb;
  import nrf_pkg::*;

  localparam int STORE_DEPTH = MAX_RECTS_DEF;
  localparam int QUIET_LIMIT = 20000;  // cycles with no word moving on either side
  localparam int HOLDOFF     = 500;    // long receiver stall for back-pressure
  localparam int DRAIN       = 300;    // settle time after the last expected word

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
    logic   last;
  } rect_item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
    logic   last;
    logic   none;
    logic   ovf;
  } kept_word_t;

  typedef enum {GEN_WIDE, GEN_TIGHT, GEN_NESTED, GEN_SAME} gen_style_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   rect_valid = 1'b0;
  logic   rect_ready;
  coord_t rect_x = '0;
  coord_t rect_y = '0;
  coord_t rect_width = '0;
  coord_t rect_height = '0;
  logic   set_end = 1'b0;
  logic   kept_valid;
  logic   kept_ready = 1'b0;
  coord_t kept_x;
  coord_t kept_y;
  coord_t kept_width;
  coord_t kept_height;
  logic   run_last;
  logic   none_kept;
  logic   overflow;

  // Stimulus queue, filled by the sequence below and drained by the driver.
  rect_item_t pending[$];
  rect_item_t nxt;
  logic       rect_took = 1'b0;
  int         send_gap_pct = 0;
  int         stall_pct = 0;
  int         holdoff_goal = 0;
  int         holdoff_served = 0;
  int         hold_left = 0;

  // Predictor state: rectangles of the open set and the words still owed.
  rect_t      rect_mem[STORE_DEPTH];
  int         rect_tally = 0;
  logic       spill_seen = 1'b0;
  kept_word_t kept_due[$];

  int mismatches = 0;
  int quiet_cycles = 0;

  nested_rectangle_filter DUT (
    .clk         (clk),
    .rst         (rst),
    .rect_valid  (rect_valid),
    .rect_ready  (rect_ready),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .set_end     (set_end),
    .kept_valid  (kept_valid),
    .kept_ready  (kept_ready),
    .kept_x      (kept_x),
    .kept_y      (kept_y),
    .kept_width  (kept_width),
    .kept_height (kept_height),
    .run_last    (run_last),
    .none_kept   (none_kept),
    .overflow    (overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // True when inner lies fully inside outer; right and bottom edges at 13 bits.
  function automatic logic encloses(input rect_t outer, input rect_t inner);
    logic [COORD_W:0] o_r, o_b, i_r, i_b;
    o_r = {1'b0, outer.x} + {1'b0, outer.w};
    o_b = {1'b0, outer.y} + {1'b0, outer.h};
    i_r = {1'b0, inner.x} + {1'b0, inner.w};
    i_b = {1'b0, inner.y} + {1'b0, inner.h};
    return outer.x <= inner.x && outer.y <= inner.y && i_r <= o_r && i_b <= o_b;
  endfunction

  // Store one accepted rectangle; on the closing word, work out the kept words.
  task automatic predict_rect(input rect_item_t it);
    rect_t      b;
    kept_word_t wd;
    logic       covered;
    int         hits;
    b = '{x: it.x, y: it.y, w: it.w, h: it.h};
    if (b.w == '0) b.w = coord_t'(1);  // zero extent counts as one pixel
    if (b.h == '0) b.h = coord_t'(1);
    if (rect_tally < STORE_DEPTH) begin
      rect_mem[rect_tally] = b;
      rect_tally++;
    end else begin
      spill_seen = 1'b1;  // drop the extra rectangle, flag the set
    end
    if (!it.last) return;
    hits = 0;
    for (int i = 0; i < rect_tally; i++) begin
      covered = 1'b0;
      for (int j = 0; j < rect_tally; j++)
        if (j != i && encloses(rect_mem[j], rect_mem[i])) covered = 1'b1;
      if (!covered) begin
        wd = '{x: rect_mem[i].x, y: rect_mem[i].y, w: rect_mem[i].w, h: rect_mem[i].h,
               last: 1'b0, none: 1'b0, ovf: spill_seen};
        kept_due = {kept_due, wd};
        hits++;
      end
    end
    if (hits == 0) begin
      // Nothing survived: owe a single empty word.
      wd = '{x: '0, y: '0, w: '0, h: '0, last: 1'b1, none: 1'b1, ovf: spill_seen};
      kept_due = {kept_due, wd};
    end else begin
      kept_due[$].last = 1'b1;
    end
    rect_tally = 0;
    spill_seen = 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input kept_word_t want,
                               input kept_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected x=%0d y=%0d w=%0d h=%0d last=%b none=%b ovf=%b,",
               $time, what, want.x, want.y, want.w, want.h, want.last, want.none, want.ovf,
               " got x=%0d y=%0d w=%0d h=%0d last=%b none=%b ovf=%b",
               got.x, got.y, got.w, got.h, got.last, got.none, got.ovf);
  endtask

  // Sample both channels at the rising edge; inputs only change at the falling edge.
  always @(posedge clk) begin
    kept_word_t got;
    kept_word_t want;
    if (rst) begin
      rect_took <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      rect_took <= rect_valid && rect_ready;
      if (rect_valid && rect_ready)
        predict_rect('{x: rect_x, y: rect_y, w: rect_width, h: rect_height, last: set_end});
      if (kept_valid && kept_ready) begin
        got = '{x: kept_x, y: kept_y, w: kept_width, h: kept_height,
                last: run_last, none: none_kept, ovf: overflow};
        if (kept_due.size() == 0) begin
          flag_mismatch("unexpected word", '0, got);
        end else begin
          want = kept_due.pop_front();
          if (got !== want) flag_mismatch("word mismatch", want, got);
        end
      end
      if ((rect_valid && rect_ready) || (kept_valid && kept_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Driver: hold the word until taken, then advance or idle at random.
  always @(negedge clk) begin
    if (rst) begin
      rect_valid <= 1'b0;
    end else if (!rect_valid || rect_took) begin
      if (pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        nxt = pending.pop_front();
        rect_x      <= nxt.x;
        rect_y      <= nxt.y;
        rect_width  <= nxt.w;
        rect_height <= nxt.h;
        set_end     <= nxt.last;
        rect_valid  <= 1'b1;
      end else begin
        rect_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      kept_ready <= 1'b0;
    end else if (hold_left > 0) begin
      kept_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holdoff_served != holdoff_goal) begin
      holdoff_served <= holdoff_goal;
      hold_left <= HOLDOFF;
      kept_ready <= 1'b0;
    end else begin
      kept_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_rect(input int x, input int y, input int w, input int h,
                           input logic last);
    rect_item_t it;
    it = '{x: coord_t'(x), y: coord_t'(y), w: coord_t'(w), h: coord_t'(h), last: last};
    pending = {pending, it};
  endtask

  // Queue one set of n rectangles shaped by style; the last one closes the set.
  task automatic queue_set(input int n, input gen_style_t style);
    int bx, by, bw, bh, x, y, w, h;
    bx = $urandom_range(3000);
    by = $urandom_range(3000);
    bw = $urandom_range(1095, 200);
    bh = $urandom_range(1095, 200);
    for (int i = 0; i < n; i++) begin
      case (style)
        GEN_WIDE: begin
          x = $urandom_range(4095);
          y = $urandom_range(4095);
          w = $urandom_range(4095);
          h = $urandom_range(4095);
        end
        GEN_TIGHT: begin
          x = $urandom_range(7);
          y = $urandom_range(7);
          w = $urandom_range(7);
          h = $urandom_range(7);
        end
        GEN_NESTED: begin
          if (i == 0 || $urandom_range(3) == 0) begin
            x = bx; y = by; w = bw; h = bh;
          end else begin
            x = bx + $urandom_range(bw / 2);
            y = by + $urandom_range(bh / 2);
            w = $urandom_range(bw - (x - bx));
            h = $urandom_range(bh - (y - by));
          end
        end
        default: begin
          x = bx; y = by; w = bw; h = bh;
        end
      endcase
      push_rect(x, y, w, h, i == n - 1);
    end
  endtask

  // Mostly short sets, some medium ones, styles mixed toward containment.
  task automatic queue_random(input int quota);
    int made, n, pick;
    gen_style_t style;
    made = 0;
    while (made < quota) begin
      n = ($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(16, 7);
      pick = $urandom_range(99);
      style = (pick < 25) ? GEN_WIDE : (pick < 60) ? GEN_TIGHT : GEN_NESTED;
      queue_set(n, style);
      made += n;
    end
  endtask

  task automatic wait_sent();
    while (pending.size() != 0 || rect_valid) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase with no idling: directed sets first.
    push_rect(0, 0, 4095, 4095, 1'b1);            // largest rectangle alone
    push_rect(12'hAAA, 12'h555, 12'h555, 12'hAAA, 1'b1);
    push_rect(10, 10, 50, 50, 1'b0);              // holds the next one
    push_rect(20, 20, 10, 10, 1'b0);
    push_rect(4000, 4000, 95, 95, 1'b0);          // edges reach 4095
    push_rect(4095, 4095, 4095, 4095, 1'b1);      // edge sums past 12 bits
    push_rect(5, 5, 5, 5, 1'b0);                  // identical pair drops both
    push_rect(5, 5, 5, 5, 1'b1);
    push_rect(100, 100, 0, 0, 1'b0);              // zero extent equals one pixel
    push_rect(100, 100, 1, 1, 1'b1);
    push_rect(200, 200, 0, 7, 1'b1);
    push_rect(4000, 0, 4095, 10, 1'b0);           // containment at 13-bit edges
    push_rect(4094, 0, 4000, 5, 1'b0);
    push_rect(0, 4095, 0, 4095, 1'b1);
    push_rect(0, 0, 10, 10, 1'b0);                // shared edges still count as inside
    push_rect(0, 0, 10, 9, 1'b0);
    push_rect(9, 0, 1, 10, 1'b1);
    queue_set(34, GEN_TIGHT);                     // overflow with duplicates
    queue_random(90);
    wait_sent();

    // Sender idles often.
    send_gap_pct = 69;
    stall_pct = 0;
    queue_set(32, GEN_NESTED);                    // exactly fills the store
    queue_random(75);
    wait_sent();

    // Receiver stalls often; one long hold-off backs the block up.
    send_gap_pct = 0;
    stall_pct = 69;
    holdoff_goal = holdoff_goal + 1;
    queue_set(33, GEN_SAME);                      // overflow and nothing kept
    queue_random(75);
    wait_sent();

    // Both sides idle now and then.
    send_gap_pct = 22;
    stall_pct = 22;
    queue_set(36, GEN_NESTED);
    queue_random(70);
    wait_sent();

    while (kept_due.size() != 0) @(negedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog: end the run when no word moves for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
